/* src/mvs_pkg.sv */
// Shared types, codes and constants of the MVCC version store.
package mvs_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int VER_W           = 6;
	localparam int CNT_W           = 7;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'h7F;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [31:0]      row_key;
		logic [31:0]      txn_key;
		logic [31:0]      snap_ver;
		logic [63:0]      payload;
		logic [VER_W-1:0] target_version;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VER_W-1:0] version_out;
		logic [31:0]      txn_out;
		logic [31:0]      snap_out;
		logic [63:0]      payload_out;
		logic             deleted_out;
		logic [CNT_W-1:0] row_version_count;
	} rsp_t;

	// One stored version as it sits in the slot memory.
	typedef struct packed {
		logic [31:0] row;
		logic [31:0] txn;
		logic [31:0] snap;
		logic [63:0] payload;
		logic        deleted;
	} entry_t;

endpackage

/* src/mvs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/mvcc_version_store.sv */
// Top level of the MVCC version store: request sequencer, slot scan and response register.
// Every transaction scans the occupied slots once, one slot read per cycle through the
// single read port of the slot memory; the scan covers the stored versions, counting one
// just created, at most TABLE_DEPTH. The response is registered, and the next transaction
// is accepted once the response register has taken the result. A new one is accepted
// while the previous response waits. Reset empties the table at once.
module mvcc_version_store #(
	parameter int TABLE_DEPTH = mvs_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mvs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mvs_pkg::rsp_t rsp
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W  = (IDX_W > mvs_pkg::VER_W) ? IDX_W : mvs_pkg::VER_W;
	localparam int ENT_W  = $bits(mvs_pkg::entry_t);

	localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(TABLE_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]               state_q;
	mvs_pkg::req_t            req_q;
	logic [FILL_W-1:0]        fill_q;
	logic [FILL_W-1:0]        scan_idx_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic                     found_q;
	logic                     full_q;
	logic [IDX_W-1:0]         hit_idx_q;
	mvs_pkg::entry_t          hit_ent_q;
	logic [mvs_pkg::CNT_W-1:0] cnt_q;
	logic                     rsp_valid_q;
	mvs_pkg::rsp_t            rsp_q;

	logic                     req_fire;
	logic                     table_full;
	logic                     rd_en;
	logic [ENT_W-1:0]         rd_raw;
	mvs_pkg::entry_t          rd_ent;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	mvs_pkg::entry_t          wr_ent;
	logic                     row_eq;
	logic                     tgt_eq;
	logic                     rsp_free;
	logic [CMP_W-1:0]         ver_ext;
	mvs_pkg::entry_t          new_ent;
	mvs_pkg::entry_t          del_ent;
	mvs_pkg::rsp_t            rsp_next;

	assign req_ready  = (state_q == S_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign table_full = (fill_q == DEPTH_C);
	assign rsp_free   = !rsp_valid_q || rsp_ready;

	assign rd_en  = (state_q == S_SCAN) && (scan_idx_q < fill_q);
	assign rd_ent = mvs_pkg::entry_t'(rd_raw);

	assign new_ent = '{row: req.row_key, txn: req.txn_key, snap: req.snap_ver,
		payload: req.payload, deleted: 1'b0};

	always_comb begin
		del_ent         = rd_ent;
		del_ent.deleted = 1'b1;
	end

	// Writes come from a create at acceptance or from the delete write-back at the end.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_ent  = hit_ent_q;
		if (req_fire && (req.op == mvs_pkg::OP_CREATE) && !table_full) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[IDX_W-1:0];
			wr_ent  = new_ent;
		end else if ((state_q == S_DONE) && rsp_free && found_q
			&& (req_q.op == mvs_pkg::OP_DELETE)) begin
			wr_en = 1'b1;
		end
	end

	mvs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(ENT_W'(wr_ent)),
		.rd_en  (rd_en),
		.rd_addr(scan_idx_q[IDX_W-1:0]),
		.rd_data(rd_raw)
	);

	assign row_eq = (rd_ent.row == req_q.row_key);
	assign tgt_eq = (CMP_W'(rd_idx_s1) == CMP_W'(req_q.target_version));

	assign ver_ext = CMP_W'(hit_idx_q);

	always_comb begin
		rsp_next                   = '0;
		rsp_next.row_version_count = cnt_q;
		if (full_q) begin
			rsp_next.status = mvs_pkg::ST_FULL;
		end else if (found_q) begin
			rsp_next.status      = mvs_pkg::ST_OK;
			rsp_next.version_out = ver_ext[mvs_pkg::VER_W-1:0];
			rsp_next.txn_out     = hit_ent_q.txn;
			rsp_next.snap_out    = hit_ent_q.snap;
			rsp_next.payload_out = hit_ent_q.payload;
			rsp_next.deleted_out = hit_ent_q.deleted;
		end else begin
			rsp_next.status = mvs_pkg::ST_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			full_q      <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_vld_s1 <= rd_en;
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						scan_idx_q <= '0;
						cnt_q      <= '0;
						full_q     <= (req.op == mvs_pkg::OP_CREATE) && table_full;
						found_q    <= (req.op == mvs_pkg::OP_CREATE) && !table_full;
						if ((req.op == mvs_pkg::OP_CREATE) && !table_full) begin
							fill_q <= FILL_W'(fill_q + 1'b1);
						end
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						scan_idx_q <= FILL_W'(scan_idx_q + 1'b1);
					end
					if (rd_vld_s1 && row_eq) begin
						if (cnt_q != mvs_pkg::CNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if ((req_q.op == mvs_pkg::OP_LOOKUP)
							&& (rd_ent.snap <= req_q.snap_ver)) begin
							found_q <= 1'b1;
						end
						if ((req_q.op == mvs_pkg::OP_DELETE) && tgt_eq) begin
							found_q <= 1'b1;
						end
					end
					if (!rd_en && !rd_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the latched request, the read index, the captured version and the response.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (req_fire) begin
			req_q     <= req;
			hit_idx_q <= fill_q[IDX_W-1:0];
			hit_ent_q <= new_ent;
		end else if ((state_q == S_SCAN) && rd_vld_s1 && row_eq) begin
			// Later slots are newer, so the last visible match wins.
			if ((req_q.op == mvs_pkg::OP_LOOKUP) && (rd_ent.snap <= req_q.snap_ver)) begin
				hit_idx_q <= rd_idx_s1;
				hit_ent_q <= rd_ent;
			end
			if ((req_q.op == mvs_pkg::OP_DELETE) && tgt_eq) begin
				hit_idx_q <= rd_idx_s1;
				hit_ent_q <= del_ent;
			end
		end
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("fill count beyond table depth");

	a_create_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && (req.op == mvs_pkg::OP_CREATE) && !table_full)
		|=> (fill_q == FILL_W'($past(fill_q) + 1'b1)))
		else $error("create did not advance the fill count");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the completion state");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |=> !(req_fire && $past(rd_vld_s1)))
		else $error("request accepted while the scan is still reading");

endmodule

/* test/tb.sv */
// Self-checking testbench for the MVCC version store: directed and random traffic against a predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ROW_POOL_N  = 6;
	localparam int DEPTH       = mvs_pkg::TABLE_DEPTH_DEF;
	localparam int TAIL_CYCLES = 2 * DEPTH + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	mvs_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	mvs_pkg::rsp_t rsp;

	// Predicted contents of the version table.
	logic            store_valid [DEPTH];
	mvs_pkg::entry_t store_entry [DEPTH];
	int              store_fill;

	mvs_pkg::rsp_t expected_rsps [$];
	mvs_pkg::rsp_t want;

	logic [31:0] row_pool [ROW_POOL_N];
	logic [31:0] snap_clock;
	logic        idle_on;
	int          stall_len;
	int          n_mismatch;
	int          n_sent;
	int          n_created, n_full, n_hits, n_misses, n_marked, n_refused, n_unused;

	mvcc_version_store u_dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("tb: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (n_mismatch < 40)
			$display("tb: mismatch at %0t ns: %s", $time, msg);
		n_mismatch++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] exp);
		if (got !== exp)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
	endtask

	function automatic mvs_pkg::rsp_t slot_echo(input int s);
		mvs_pkg::rsp_t o;
		o = '0;
		o.status      = mvs_pkg::ST_OK;
		o.version_out = s[mvs_pkg::VER_W-1:0];
		o.txn_out     = store_entry[s].txn;
		o.snap_out    = store_entry[s].snap;
		o.payload_out = store_entry[s].payload;
		o.deleted_out = store_entry[s].deleted;
		return o;
	endfunction

	// Applies one accepted transaction to the predicted table and returns its response.
	function automatic mvs_pkg::rsp_t apply_to_store(input mvs_pkg::req_t r);
		mvs_pkg::rsp_t o;
		int   hit;
		int   cnt;
		o = '0;
		o.status = mvs_pkg::ST_NOT_FOUND;
		hit = -1;
		cnt = 0;
		case (r.op)
			mvs_pkg::OP_CREATE: begin
				if (store_fill >= DEPTH) begin
					o.status = mvs_pkg::ST_FULL;
					n_full++;
				end else begin
					store_valid[store_fill] = 1'b1;
					store_entry[store_fill] = '{row: r.row_key, txn: r.txn_key,
						snap: r.snap_ver, payload: r.payload, deleted: 1'b0};
					o = slot_echo(store_fill);
					store_fill++;
					n_created++;
				end
			end
			mvs_pkg::OP_LOOKUP: begin
				// Slots fill in creation order, so the last match is the newest one.
				for (int i = 0; i < DEPTH; i++)
					if (store_valid[i] && store_entry[i].row == r.row_key &&
							store_entry[i].snap <= r.snap_ver)
						hit = i;
				if (hit >= 0) begin
					o = slot_echo(hit);
					n_hits++;
				end else
					n_misses++;
			end
			mvs_pkg::OP_DELETE: begin
				if (store_valid[r.target_version] &&
						store_entry[r.target_version].row == r.row_key) begin
					store_entry[r.target_version].deleted = 1'b1;
					o = slot_echo(r.target_version);
					n_marked++;
				end else
					n_refused++;
			end
			default: n_unused++;
		endcase
		for (int i = 0; i < DEPTH; i++)
			if (store_valid[i] && store_entry[i].row == r.row_key)
				cnt++;
		o.row_version_count = (cnt > mvs_pkg::CNT_MAX) ? mvs_pkg::CNT_MAX
			: cnt[mvs_pkg::CNT_W-1:0];
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_request(input mvs_pkg::req_t r);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsps = {expected_rsps, apply_to_store(r)};
		n_sent++;
	endtask

	task automatic drain_pending();
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	function automatic mvs_pkg::req_t make_req(input logic [1:0] op, input logic [31:0] row,
			input logic [31:0] txn, input logic [31:0] snap, input logic [63:0] pay,
			input logic [mvs_pkg::VER_W-1:0] tgt);
		mvs_pkg::req_t r;
		r.op             = op;
		r.row_key        = row;
		r.txn_key        = txn;
		r.snap_ver       = snap;
		r.payload        = pay;
		r.target_version = tgt;
		return r;
	endfunction

	function automatic logic [31:0] pick_row();
		if ($urandom_range(0, 99) < 85)
			return row_pool[$urandom_range(0, ROW_POOL_N - 1)];
		return $urandom;
	endfunction

	// Mostly well-formed traffic: lookups and deletes aim at versions that exist.
	function automatic mvs_pkg::req_t make_random_request(input int create_pct);
		mvs_pkg::req_t r;
		int   pick;
		int   s;
		r.op             = mvs_pkg::OP_LOOKUP;
		r.row_key        = pick_row();
		r.txn_key        = $urandom;
		r.snap_ver       = $urandom;
		r.payload        = {$urandom, $urandom};
		r.target_version = mvs_pkg::VER_W'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < create_pct) begin
			r.op = mvs_pkg::OP_CREATE;
			if ($urandom_range(0, 9) < 6) begin
				snap_clock = snap_clock + $urandom_range(0, 3);
				r.snap_ver = snap_clock;
			end
		end else if (pick < create_pct + 55) begin
			r.op = mvs_pkg::OP_LOOKUP;
			if (store_fill > 0 && $urandom_range(0, 9) < 8) begin
				s = $urandom_range(0, store_fill - 1);
				r.row_key = store_entry[s].row;
				case ($urandom_range(0, 5))
					0, 1: r.snap_ver = store_entry[s].snap;
					2: r.snap_ver = store_entry[s].snap - 32'd1;
					3: r.snap_ver = store_entry[s].snap + 32'd1;
					4: r.snap_ver = '0;
					default: r.snap_ver = '1;
				endcase
			end
		end else if (pick < 95) begin
			r.op = mvs_pkg::OP_DELETE;
			if (store_fill > 0 && $urandom_range(0, 9) < 7) begin
				s = $urandom_range(0, store_fill - 1);
				r.target_version = s[mvs_pkg::VER_W-1:0];
				r.row_key        = store_entry[s].row;
			end
		end else
			r.op = OP_UNUSED;
		return r;
	endfunction

	always begin
		@(negedge clk);
		if (!idle_on || $urandom_range(0, 99) < 70) begin
			rsp_ready = 1'b1;
		end else begin
			rsp_ready = 1'b0;
			stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
				: $urandom_range(1, 3);
			repeat (stall_len - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("response with no transaction outstanding");
			end else begin
				want = expected_rsps.pop_front();
				check_field("status", 64'(rsp.status), 64'(want.status));
				check_field("version_out", 64'(rsp.version_out), 64'(want.version_out));
				check_field("txn_out", 64'(rsp.txn_out), 64'(want.txn_out));
				check_field("snap_out", 64'(rsp.snap_out), 64'(want.snap_out));
				check_field("payload_out", rsp.payload_out, want.payload_out);
				check_field("deleted_out", 64'(rsp.deleted_out), 64'(want.deleted_out));
				check_field("row_version_count", 64'(rsp.row_version_count),
					64'(want.row_version_count));
			end
		end
	end

	task automatic test_empty_table();
		send_request(make_req(mvs_pkg::OP_LOOKUP, 32'h0, 32'h0, '1, '0, '0));
		send_request(make_req(mvs_pkg::OP_DELETE, 32'h0, 32'h0, 32'h0, '0, '0));
		send_request(make_req(OP_UNUSED, '1, '1, '1, '1, '1));
	endtask

	task automatic test_versions_and_visibility();
		logic [31:0] row_a;
		row_a = 32'h5A5A_0001;
		send_request(make_req(mvs_pkg::OP_CREATE, 32'h0, 32'h0, 32'h0, 64'h0, '0));
		send_request(make_req(mvs_pkg::OP_CREATE, '1, '1, '1, '1, '1));
		send_request(make_req(mvs_pkg::OP_CREATE, row_a, 32'd11, 32'd10, 64'hA0, '0));
		send_request(make_req(mvs_pkg::OP_CREATE, row_a, 32'd12, 32'd20, 64'hA1, '0));
		send_request(make_req(mvs_pkg::OP_CREATE, row_a, 32'd13, 32'd30, 64'hA2, '0));
		// Newest version carries an older snapshot than the one before it.
		send_request(make_req(mvs_pkg::OP_CREATE, row_a, 32'd14, 32'd25, 64'hA3, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, row_a, '0, 32'd9, '0, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, row_a, '0, 32'd10, '0, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, row_a, '0, 32'd20, '0, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, row_a, '0, '1, '0, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, 32'h0, '0, 32'h0, '0, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, '1, '0, '1, '0, '0));
		send_request(make_req(mvs_pkg::OP_LOOKUP, '1, '0, 32'hFFFF_FFFE, '0, '0));
	endtask

	task automatic test_delete_marks();
		logic [31:0] row_a;
		row_a = 32'h5A5A_0001;
		send_request(make_req(mvs_pkg::OP_DELETE, row_a, '0, '0, '0, 6'd3));
		send_request(make_req(mvs_pkg::OP_DELETE, row_a, '0, '0, '0, 6'd3));
		send_request(make_req(mvs_pkg::OP_LOOKUP, row_a, '0, 32'd20, '0, '0));
		send_request(make_req(mvs_pkg::OP_DELETE, 32'h0, '0, '0, '0, 6'd3));
		send_request(make_req(mvs_pkg::OP_DELETE, row_a, '0, '0, '0, 6'd63));
		send_request(make_req(OP_UNUSED, row_a, '0, '0, '0, '0));
	endtask

	task automatic test_random_traffic(input int n, input int create_pct);
		repeat (n) send_request(make_random_request(create_pct));
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			store_valid[i] = 1'b0;
			store_entry[i] = '0;
		end
		store_fill  = 0;
		snap_clock  = 32'd100;
		idle_on     = 1'b0;
		n_mismatch  = 0;
		n_sent      = 0;
		n_created   = 0;
		n_full      = 0;
		n_hits      = 0;
		n_misses    = 0;
		n_marked    = 0;
		n_refused   = 0;
		n_unused    = 0;
		row_pool[0] = 32'h0;
		row_pool[1] = '1;
		for (int i = 2; i < ROW_POOL_N; i++)
			row_pool[i] = $urandom;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_versions_and_visibility();
		idle_on = 1'b1;
		test_delete_marks();
		test_random_traffic(700, 8);
		// Let the table settle completely before the next burst.
		drain_pending();
		idle_on = 1'b0;
		test_random_traffic(350, 6);
		idle_on = 1'b1;
		test_random_traffic(500, 5);

		drain_pending();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d transactions; %0d versions created, %0d creates refused as full",
			n_sent, n_created, n_full);
		$display("tb: lookups %0d visible, %0d not visible; marks %0d set, %0d refused; %0d unused",
			n_hits, n_misses, n_marked, n_refused, n_unused);
		if (n_mismatch == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
